// File: rtl/sbs_pkg.sv
package sbs_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_CELL_WIDTH  = 32;
	localparam int OPERAND_W       = 32;
	localparam int CMD_W           = 3;
	localparam int STATUS_W        = 3;
	localparam int DEPTH_OUT_W     = 7;

	localparam logic [CMD_W-1:0] OP_CALL        = 3'd0;
	localparam logic [CMD_W-1:0] OP_LITERAL     = 3'd1;
	localparam logic [CMD_W-1:0] OP_BRANCH      = 3'd2;
	localparam logic [CMD_W-1:0] OP_BRANCH_IF   = 3'd3;
	localparam logic [CMD_W-1:0] OP_BRANCH_UNLS = 3'd4;
	localparam logic [CMD_W-1:0] OP_RETURN      = 3'd5;

	localparam logic [STATUS_W-1:0] ST_CONTINUE  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RETURNED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CALL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]            cmd;
		logic signed [OPERAND_W-1:0] operand;
	} sbs_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0]         status;
		logic signed [OPERAND_W-1:0] ip_step;
		logic signed [OPERAND_W-1:0] call_target;
		logic [DEPTH_OUT_W-1:0]      stack_depth;
	} sbs_out_t;

	// shift command common to every cell of the stack
	typedef struct packed {
		logic push;
		logic pop;
	} sbs_cell_op_t;

endpackage

// File: rtl/stack_bytecode_step.sv
// Executes one stack-machine instruction per transfer on start.
// The result strobe (done) is registered and comes in the cycle after the transfer.
// Throughput: one instruction per cycle; busy stays low, since the stack is a
// row of shift cells whose top is read and moved in the same cycle as the decode.
// Reset clears the depth count and the strobe; cell contents are undefined until pushed.
module stack_bytecode_step import sbs_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int CELL_WIDTH  = DEF_CELL_WIDTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sbs_in_t  instr,
	output logic     done,
	output sbs_out_t result
);

	logic [CELL_WIDTH-1:0] cell_q [STACK_DEPTH];
	logic [CELL_WIDTH-1:0] push_d [STACK_DEPTH];
	logic [CELL_WIDTH-1:0] pop_d  [STACK_DEPTH];
	logic [CELL_WIDTH-1:0] lit;
	sbs_cell_op_t          op;

	assign busy = 1'b0;

	sbs_ctrl #(
		.STACK_DEPTH(STACK_DEPTH),
		.CELL_WIDTH (CELL_WIDTH)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.instr (instr),
		.top   (cell_q[0]),
		.op    (op),
		.lit   (lit),
		.done  (done),
		.result(result)
	);

	// cell 0 is the top of stack
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_top
			assign push_d[i] = lit;
		end else begin : g_mid
			assign push_d[i] = cell_q[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign pop_d[i] = '0;
		end else begin : g_inner
			assign pop_d[i] = cell_q[i+1];
		end

		sbs_cell #(
			.CELL_WIDTH(CELL_WIDTH)
		) u_cell (
			.clk   (clk),
			.op    (op),
			.push_d(push_d[i]),
			.pop_d (pop_d[i]),
			.data_q(cell_q[i])
		);
	end

endmodule

// File: rtl/sbs_cell.sv
module sbs_cell import sbs_pkg::*; #(
	parameter int CELL_WIDTH = DEF_CELL_WIDTH
) (
	input  logic                  clk,
	input  sbs_cell_op_t          op,
	input  logic [CELL_WIDTH-1:0] push_d,
	input  logic [CELL_WIDTH-1:0] pop_d,
	output logic [CELL_WIDTH-1:0] data_q
);

	// push takes the value from the cell above, pop from the cell below
	always_ff @(posedge clk) begin
		if (op.push) begin
			data_q <= push_d;
		end else if (op.pop) begin
			data_q <= pop_d;
		end
	end

endmodule

// File: rtl/sbs_ctrl.sv
module sbs_ctrl import sbs_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int CELL_WIDTH  = DEF_CELL_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  sbs_in_t               instr,
	input  logic [CELL_WIDTH-1:0] top,
	output sbs_cell_op_t          op,
	output logic [CELL_WIDTH-1:0] lit,
	output logic                  done,
	output sbs_out_t              result
);

	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic [DW-1:0] cnt_q;
	logic [DW-1:0] cnt_d;
	logic          done_q;
	sbs_out_t      res_q;
	sbs_out_t      res_d;
	logic          full;
	logic          empty;
	logic          cond;

	assign full  = (cnt_q == DW'(STACK_DEPTH));
	assign empty = (cnt_q == '0);
	assign lit   = CELL_WIDTH'($signed(instr.operand));
	// take the branch when the nonzero test agrees with the opcode
	assign cond  = (instr.cmd == OP_BRANCH_IF) == (top != '0);

	always_comb begin
		op                = '0;
		cnt_d             = cnt_q;
		res_d.status      = ST_CONTINUE;
		res_d.ip_step     = 32'sd1;
		res_d.call_target = '0;
		case (instr.cmd)
			OP_CALL: begin
				res_d.status      = ST_CALL;
				res_d.call_target = instr.operand;
			end
			OP_LITERAL: begin
				if (full) begin
					res_d.status  = ST_OVERFLOW;
					res_d.ip_step = '0;
				end else begin
					op.push = start;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			OP_BRANCH: begin
				res_d.ip_step = instr.operand;
			end
			OP_BRANCH_IF, OP_BRANCH_UNLS: begin
				if (empty) begin
					res_d.status  = ST_UNDERFLOW;
					res_d.ip_step = '0;
				end else begin
					op.pop = start;
					cnt_d  = cnt_q - 1'b1;
					if (cond) begin
						res_d.ip_step = instr.operand;
					end
				end
			end
			OP_RETURN: begin
				res_d.status  = ST_RETURNED;
				res_d.ip_step = '0;
			end
			default: begin
				res_d.status  = ST_INVALID;
				res_d.ip_step = '0;
			end
		endcase
		res_d.stack_depth = DEPTH_OUT_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= start;
			if (start) begin
				cnt_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			res_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> done) else $error("transfer without result strobe");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DW'(STACK_DEPTH)) else $error("depth count beyond stack size");

	a_depth_report: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.stack_depth == DEPTH_OUT_W'(cnt_q))
		else $error("reported depth differs from count");

	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_UNDERFLOW || result.status == ST_OVERFLOW
			|| result.status == ST_INVALID || result.status == ST_CALL)
		|-> cnt_q == $past(cnt_q)) else $error("stack moved on call or error");

	a_err_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_UNDERFLOW || result.status == ST_OVERFLOW
			|| result.status == ST_INVALID || result.status == ST_RETURNED)
		|-> result.ip_step == '0) else $error("nonzero step on error or return");

	a_one_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(op.push && op.pop)) else $error("push and pop together");

endmodule
